[rtl/core/pnid_pkg.sv]
package pnid_pkg;

  localparam int DIV_NUM_W = 13;
  localparam int DIV_DEN_W = 7;

  localparam logic [6:0] SCALE_FULL = 7'd64;

  localparam logic [7:0] NIB_HI_MASK = 8'hf0;
  localparam logic [7:0] NIB_LO_MASK = 8'h0f;

  localparam logic [2:0] REG_SCALE       = 3'd0;
  localparam logic [2:0] REG_ROW_BYTES   = 3'd1;
  localparam logic [2:0] REG_OUT_BYTES   = 3'd2;
  localparam logic [2:0] REG_MIRROR      = 3'd3;
  localparam logic [2:0] REG_SOURCE_ROWS = 3'd4;

  typedef logic [DIV_NUM_W-1:0] div_word_t;

endpackage

[rtl/core/pnid_ram.sv]
module pnid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/pnid_div.sv]
module pnid_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  pnid_pkg::div_word_t                 num_in,
  input  logic [pnid_pkg::DIV_DEN_W-1:0]      den,
  output logic                                done,
  output pnid_pkg::div_word_t                 quo
);

  localparam int CNT_W = $clog2(pnid_pkg::DIV_NUM_W + 1);
  localparam int REM_W = pnid_pkg::DIV_DEN_W - 1;

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [REM_W-1:0]      rem;
  pnid_pkg::div_word_t   num;
  logic [pnid_pkg::DIV_DEN_W-1:0] shifted;
  logic                  ge;

  assign shifted = {rem, num[pnid_pkg::DIV_NUM_W-1]};
  assign ge      = shifted >= den;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(pnid_pkg::DIV_NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      num <= num_in;
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? REM_W'(shifted - den) : shifted[REM_W-1:0];
      num <= num << 1;
      quo <= {quo[pnid_pkg::DIV_NUM_W-2:0], ge};
    end
  end

endmodule

[rtl/core/packed_nibble_image_downscaler.sv]
// Nearest-neighbour downscaler for packed 4-bit images. Source bytes (two pixels, high nibble
// first) are taken one per cycle into a row buffer while a row fills; a byte that completes a
// dropped row is taken without a stall too. For a kept row the block stalls its input and
// emits out_bytes_minus_one+1 bytes (capped at OUT_ROW_MAX). Each picked pixel position,
// floor(64*k/scale), comes from one shared 13-step restoring divider followed by a row-buffer
// read; every output byte takes two pixel picks and is then held while res_stall is high.
// Configuration goes through the APB port at byte addresses 0, 4, 8, 12 and 16 and must be
// written only while the block is idle.
module packed_nibble_image_downscaler #(
  parameter int ROW_STORE_DEPTH = 256,
  parameter int OUT_ROW_MAX     = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        src_valid,
  output logic        src_stall,
  input  logic [7:0]  src_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  out_byte,
  output logic        row_end,
  output logic        tile_end,
  output logic        overrun
);

  localparam int AW = $clog2(ROW_STORE_DEPTH);
  localparam logic [5:0] OUT_LAST = 6'(OUT_ROW_MAX - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_ADDR = 3'd2;
  localparam logic [2:0] ST_DATA = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [6:0] scale;
  logic [7:0] row_bytes;
  logic [5:0] out_bytes_minus_one;
  logic       mirror;
  logic [7:0] source_rows;

  logic [2:0] state;
  logic [7:0] pos;
  logic [5:0] acc;
  logic [7:0] row_cnt;
  logic       final_kept;
  logic [5:0] k;
  logic       phase;
  logic [3:0] hi_nib;
  logic       hi_past;
  logic       rd_past;
  logic       rd_inr;
  logic       rd_lo;

  logic       cfg_wr;
  logic       src_acc;
  logic [6:0] s_eff;
  logic [7:0] rb;
  logic [7:0] rows;
  logic [5:0] nlast;
  logic       row_done;
  logic       kept;
  logic [5:0] acc_step;
  logic       last_row;
  logic [7:0] rows_left;
  logic [14:0] need;
  logic       fin_now;

  logic                 div_start;
  pnid_pkg::div_word_t  div_num;
  logic                 div_done;
  pnid_pkg::div_word_t  div_quo;

  logic [11:0] wbyte;
  logic        w_past;
  logic [7:0]  phys;
  logic        phys_inr;
  logic        ram_we;
  logic [7:0]  ram_rdata;
  logic [7:0]  rd_val;
  logic [3:0]  nib;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale               <= pnid_pkg::SCALE_FULL;
      row_bytes           <= 8'd1;
      out_bytes_minus_one <= 6'd0;
      mirror              <= 1'b0;
      source_rows         <= 8'd1;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        pnid_pkg::REG_SCALE:       scale               <= pwdata[6:0];
        pnid_pkg::REG_ROW_BYTES:   row_bytes           <= pwdata[7:0];
        pnid_pkg::REG_OUT_BYTES:   out_bytes_minus_one <= pwdata[5:0];
        pnid_pkg::REG_MIRROR:      mirror              <= pwdata[0];
        pnid_pkg::REG_SOURCE_ROWS: source_rows         <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      pnid_pkg::REG_SCALE:       prdata = {25'd0, scale};
      pnid_pkg::REG_ROW_BYTES:   prdata = {24'd0, row_bytes};
      pnid_pkg::REG_OUT_BYTES:   prdata = {26'd0, out_bytes_minus_one};
      pnid_pkg::REG_MIRROR:      prdata = {31'd0, mirror};
      pnid_pkg::REG_SOURCE_ROWS: prdata = {24'd0, source_rows};
      default:                   prdata = 32'd0;
    endcase
  end

  // effective settings
  always_comb begin
    priority if (scale == 7'd0) begin
      s_eff = 7'd1;
    end else if (scale > pnid_pkg::SCALE_FULL) begin
      s_eff = pnid_pkg::SCALE_FULL;
    end else begin
      s_eff = scale;
    end
  end

  assign rb    = (row_bytes == 8'd0) ? 8'd1 : row_bytes;
  assign rows  = (source_rows == 8'd0) ? 8'd1 : source_rows;
  assign nlast = (out_bytes_minus_one > OUT_LAST) ? OUT_LAST : out_bytes_minus_one;

  // row completion
  assign src_stall = state != ST_IDLE;
  assign src_acc   = src_valid && !src_stall;
  assign row_done  = !(({1'b0, pos} + 9'd1) < {1'b0, rb});
  assign kept      = {1'b0, acc} < s_eff;
  assign acc_step  = acc - s_eff[5:0];
  assign last_row  = !(({1'b0, row_cnt} + 9'd1) < {1'b0, rows});
  assign rows_left = rows - 8'd1 - row_cnt;
  assign need      = rows_left * s_eff;
  assign fin_now   = last_row || (need <= {9'd0, acc_step});

  // row buffer
  assign ram_we = src_acc && ({1'b0, pos} < 9'(ROW_STORE_DEPTH));

  pnid_ram #(
    .WIDTH (8),
    .DEPTH (ROW_STORE_DEPTH)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos[AW-1:0]),
    .wdata (src_byte),
    .raddr (phys[AW-1:0]),
    .rdata (ram_rdata)
  );

  // pixel pick position
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    unique case (state)
      ST_IDLE: div_start = src_acc && row_done && kept;
      ST_DATA: begin
        div_start = !phase;
        div_num   = {k, 1'b1, 6'd0};
      end
      ST_OUT: begin
        div_start = !res_stall && (k != nlast);
        div_num   = {k + 6'd1, 1'b0, 6'd0};
      end
      default: ;
    endcase
  end

  pnid_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num_in (div_num),
    .den    (s_eff),
    .done   (div_done),
    .quo    (div_quo)
  );

  assign wbyte    = div_quo[pnid_pkg::DIV_NUM_W-1:1];
  assign w_past   = wbyte >= {4'd0, rb};
  assign phys     = mirror ? (rb - 8'd1 - wbyte[7:0]) : wbyte[7:0];
  assign phys_inr = {1'b0, phys} < 9'(ROW_STORE_DEPTH);

  assign rd_val = rd_inr ? ram_rdata : 8'd0;
  always_comb begin
    if (rd_past) begin
      nib = 4'd0;
    end else if (rd_lo) begin
      nib = 4'(rd_val & pnid_pkg::NIB_LO_MASK);
    end else begin
      nib = 4'((rd_val & pnid_pkg::NIB_HI_MASK) >> 4);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      acc       <= '0;
      row_cnt   <= '0;
      k         <= '0;
      phase     <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (src_acc) begin
            if (!row_done) begin
              pos <= pos + 8'd1;
            end else begin
              pos <= '0;
              if (last_row) begin
                row_cnt <= '0;
                acc     <= '0;
              end else begin
                row_cnt <= row_cnt + 8'd1;
                acc     <= acc_step;
              end
              if (kept) begin
                k     <= '0;
                phase <= 1'b0;
                state <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_ADDR;
          end
        end
        ST_ADDR: state <= ST_DATA;
        ST_DATA: begin
          if (!phase) begin
            phase <= 1'b1;
            state <= ST_DIV;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!res_stall) begin
            if (k == nlast) begin
              state <= ST_IDLE;
            end else begin
              k     <= k + 6'd1;
              phase <= 1'b0;
              state <= ST_DIV;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && src_acc && row_done) begin
      final_kept <= fin_now;
    end
    if (state == ST_ADDR) begin
      rd_past <= w_past;
      rd_inr  <= phys_inr;
      rd_lo   <= div_quo[0];
    end
    if (state == ST_DATA) begin
      if (!phase) begin
        hi_nib  <= nib;
        hi_past <= rd_past;
      end else begin
        out_byte <= {hi_nib, nib};
        overrun  <= hi_past || rd_past;
        row_end  <= k == nlast;
        tile_end <= (k == nlast) && final_kept;
      end
    end
  end

  assign res_valid = state == ST_OUT;

  a_res_blocks_src: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> src_stall)
    else $error("input taken while a result is pending");

  a_tile_on_row: assert property (@(posedge clk) disable iff (rst)
    res_valid && tile_end |-> row_end)
    else $error("tile end without row end");

  a_div_in_seq: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside its wait state");

  a_row_end_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && row_end |=> !src_stall)
    else $error("not ready for requests after the last byte of a row");

endmodule
